// ===== src/nsc_pkg.sv =====
// Shared types, constants and helper functions for the NMEA sentence checker.
package nsc_pkg;

    localparam int unsigned MAX_SENTENCE_LEN = 128;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    localparam int unsigned NUM_KINDS  = 7;
    localparam int unsigned HDR_CHARS  = 5;
    localparam logic [2:0]  HDR_LAST   = 3'(HDR_CHARS - 1);
    localparam logic [5:0]  FIELD_MAX  = 6'd63;
    localparam logic [2:0]  KIND_NONE  = 3'd7;
    localparam logic [7:0]  LEN_LIMIT  = 8'(MAX_SENTENCE_LEN);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_HEAD,
        MODE_BODY,
        MODE_CK1,
        MODE_CK2
    } mode_t;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_OK      = 2'd1,
        ST_BAD     = 2'd2,
        ST_DISCARD = 2'd3
    } status_t;

    typedef logic [8*HDR_CHARS-1:0] header_t;

    // Packed sentence headers, first character in the top byte.
    localparam header_t KIND_HEADERS [NUM_KINDS] = '{
        40'h4750474741,   // GPGGA
        40'h4750474C4C,   // GPGLL
        40'h4750475341,   // GPGSA
        40'h4750475356,   // GPGSV
        40'h4750524D43,   // GPRMC
        40'h4750565447,   // GPVTG
        40'h47505A4441    // GPZDA
    };

    // Upper-case hex digit value; bit 4 set for anything else.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h41 + 8'd10);
        end
        return v;
    endfunction

    function automatic logic [2:0] match_header(input header_t packed_hdr);
        logic [2:0] k;
        k = KIND_NONE;
        for (int i = NUM_KINDS - 1; i >= 0; i--) begin
            if (packed_hdr == KIND_HEADERS[i]) begin
                k = 3'(i);
            end
        end
        return k;
    endfunction

endpackage

// ===== src/nsc_parser.sv =====
// Sentence parse state, per-character decode and the result register.
module nsc_parser
    import nsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] char_in,
    output logic [7:0] char_out,
    output logic [5:0] field_number,
    output logic       in_field,
    output logic [2:0] sentence_kind,
    output logic [1:0] status
);

    mode_t       mode_reg, mode_next;
    logic [7:0]  xor_reg, xor_next;
    header_t     hdr_reg, hdr_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [5:0]  field_cnt_reg, field_cnt_next;
    logic [7:0]  len_reg, len_next;
    logic [4:0]  ck_high_reg, ck_high_next;
    logic [2:0]  kind_reg, kind_next;

    logic [7:0]  char_reg;
    logic [5:0]  fnum_reg, fnum_next;
    logic        inf_reg, inf_next;
    logic [2:0]  okind_reg, okind_next;
    status_t     st_reg, st_next;

    logic [4:0]  hex_lo;
    logic [2:0]  hdr_match;
    header_t     hdr_shift;

    always_comb begin
        hdr_shift = {hdr_reg[8*(HDR_CHARS-1)-1:0], char_in};
        hdr_match = match_header(hdr_shift);
        hex_lo    = hex_value(char_in);

        mode_next      = mode_reg;
        xor_next       = xor_reg;
        hdr_next       = hdr_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        field_cnt_next = field_cnt_reg;
        len_next       = len_reg;
        ck_high_next   = ck_high_reg;
        kind_next      = kind_reg;

        fnum_next  = '0;
        inf_next   = 1'b0;
        okind_next = KIND_NONE;
        st_next    = ST_NONE;

        if (char_in == CHAR_DOLLAR) begin
            // restart on every dollar; drop any open sentence
            if (mode_reg != MODE_IDLE) begin
                st_next = ST_DISCARD;
            end
            mode_next      = MODE_HEAD;
            xor_next       = '0;
            hdr_next       = '0;
            hdr_cnt_next   = '0;
            field_cnt_next = '0;
            len_next       = 8'd1;
            ck_high_next   = '0;
            kind_next      = KIND_NONE;
        end else if (mode_reg == MODE_IDLE) begin
            // pass through
        end else if (len_reg >= LEN_LIMIT) begin
            fnum_next  = field_cnt_reg;
            okind_next = kind_reg;
            st_next    = ST_DISCARD;
            mode_next  = MODE_IDLE;
            kind_next  = KIND_NONE;
        end else begin
            len_next   = len_reg + 8'd1;
            fnum_next  = field_cnt_reg;
            okind_next = kind_reg;
            case (mode_reg)
                MODE_HEAD: begin
                    xor_next     = xor_reg ^ char_in;
                    hdr_next     = hdr_shift;
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    if (hdr_cnt_reg >= HDR_LAST) begin
                        if (hdr_match == KIND_NONE) begin
                            okind_next = KIND_NONE;
                            st_next    = ST_DISCARD;
                            mode_next  = MODE_IDLE;
                            kind_next  = KIND_NONE;
                        end else begin
                            kind_next  = hdr_match;
                            okind_next = hdr_match;
                            mode_next  = MODE_BODY;
                        end
                    end
                end
                MODE_BODY: begin
                    if (char_in == CHAR_STAR) begin
                        mode_next = MODE_CK1;
                    end else if (char_in == CHAR_COMMA) begin
                        xor_next = xor_reg ^ char_in;
                        if (field_cnt_reg < FIELD_MAX) begin
                            field_cnt_next = field_cnt_reg + 6'd1;
                        end
                    end else begin
                        xor_next = xor_reg ^ char_in;
                        inf_next = 1'b1;
                    end
                end
                MODE_CK1: begin
                    ck_high_next = hex_lo;
                    mode_next    = MODE_CK2;
                end
                MODE_CK2: begin
                    if (!ck_high_reg[4] && !hex_lo[4] &&
                        {ck_high_reg[3:0], hex_lo[3:0]} == xor_reg) begin
                        st_next = ST_OK;
                    end else begin
                        st_next = ST_BAD;
                    end
                    mode_next = MODE_IDLE;
                    kind_next = KIND_NONE;
                end
                default: begin
                    mode_next = MODE_IDLE;
                    kind_next = KIND_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            xor_reg       <= '0;
            hdr_reg       <= '0;
            hdr_cnt_reg   <= '0;
            field_cnt_reg <= '0;
            len_reg       <= '0;
            ck_high_reg   <= '0;
            kind_reg      <= KIND_NONE;
        end else if (step_en) begin
            mode_reg      <= mode_next;
            xor_reg       <= xor_next;
            hdr_reg       <= hdr_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            field_cnt_reg <= field_cnt_next;
            len_reg       <= len_next;
            ck_high_reg   <= ck_high_next;
            kind_reg      <= kind_next;
        end
    end

    // result payload; valid is kept by the top level
    always_ff @(posedge aclk) begin
        if (step_en) begin
            char_reg  <= char_in;
            fnum_reg  <= fnum_next;
            inf_reg   <= inf_next;
            okind_reg <= okind_next;
            st_reg    <= st_next;
        end
    end

    assign char_out      = char_reg;
    assign field_number  = fnum_reg;
    assign in_field      = inf_reg;
    assign sentence_kind = okind_reg;
    assign status        = st_reg;

endmodule

// ===== src/nmea_sentence_checker.sv =====
// NMEA 0183 sentence checker top level: input register, parser, result handshake.
//
//  channel | direction | payload                                              | handshake
//  s_      | in        | data_byte[7:0]                                       | s_valid/s_ready
//  m_      | out       | char_out, field_number, in_field, sentence_kind,     | m_valid/m_ready
//          |           | status                                               |
//
// One character per cycle sustained while m_ready keeps the result moving; each accepted
// character passes through the input register and is then parsed into the result register,
// from which it leaves when m_ready is high.
// Each character yields exactly one result transaction.
// Reset (aresetn low, synchronous) empties both registers and returns the parser to idle.
// A stall on m_ready holds the result; an empty input register still takes one more
// character, then s_ready drops until the result moves.
module nmea_sentence_checker
    import nsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_out,
    output logic [5:0] m_field_number,
    output logic       m_in_field,
    output logic [2:0] m_sentence_kind,
    output logic [1:0] m_status
);

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       out_valid_reg;
    logic       advance;

    // move the held character into the result register when it has room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
        end
    end

    nsc_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .char_in       (in_data_reg),
        .char_out      (m_char_out),
        .field_number  (m_field_number),
        .in_field      (m_in_field),
        .sentence_kind (m_sentence_kind),
        .status        (m_status)
    );

    assign m_valid = out_valid_reg;

endmodule

// ===== src/nsc_checker.sv =====
// Port-level assertions for the NMEA sentence checker, bound to the top level.
module nsc_checker
    import nsc_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_char_out,
    input logic [5:0] m_field_number,
    input logic       m_in_field,
    input logic [2:0] m_sentence_kind,
    input logic [1:0] m_status
);

    // no result right after a reset cycle
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_out) && $stable(m_status))
        else $error("stalled result changed");

    // a passing checksum only closes a sentence with a recognized header
    a_ok_has_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> m_sentence_kind != KIND_NONE && !m_in_field)
        else $error("checksum ok without a known sentence kind");

    // field content belongs to a recognized sentence and is never a delimiter
    a_field_content: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_field |->
            m_sentence_kind != KIND_NONE && m_status == ST_NONE &&
            m_char_out != CHAR_COMMA && m_char_out != CHAR_STAR &&
            m_char_out != CHAR_DOLLAR)
        else $error("field content flag on a non-content character");

    // a dollar always restarts at the header with no kind
    a_dollar_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_out == CHAR_DOLLAR |->
            m_field_number == 6'd0 && m_sentence_kind == KIND_NONE &&
            (m_status == ST_NONE || m_status == ST_DISCARD))
        else $error("dollar did not restart the sentence");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (.*);

// ===== verif/tb_nmea_sentence_checker.sv =====
// Self-checking testbench for the NMEA sentence checker: directed table, random sentences.
module tb_nmea_sentence_checker;
    import nsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1050;
    localparam int N_DIRECTED   = 30;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;

    localparam logic [2:0] KIND_GGA = 3'd0;
    localparam logic [2:0] KIND_ZDA = 3'd6;

    localparam header_t SENT_HDRS [7] = '{
        "GPGGA", "GPGLL", "GPGSA", "GPGSV", "GPRMC", "GPVTG", "GPZDA"
    };

    typedef enum int {
        SENT_GOOD,
        SENT_BADSUM,
        SENT_BADDIGIT,
        SENT_UNKNOWN,
        SENT_LONG,
        SENT_MANYFIELDS,
        SENT_CUT
    } shape_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [5:0] field;
        logic       in_field;
        logic [2:0] kind;
        status_t    status;
    } char_result_t;

    typedef struct packed {
        logic         typed;
        char_result_t res;
    } stim_entry_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_char_out;
    logic [5:0] m_field_number;
    logic       m_in_field;
    logic [2:0] m_sentence_kind;
    logic [1:0] m_status;

    stim_entry_t  stim_q [$];
    stim_entry_t  directed_rows [N_DIRECTED];
    char_result_t expected_chars [$];
    char_result_t rx_expect;

    int  feed_idx = 0;
    int  chars_accepted = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    logic rx_hold = 1'b0;

    // sentence tracker state
    mode_t      trk_mode = MODE_IDLE;
    logic [7:0] trk_xor = '0;
    header_t    trk_hdr = '0;
    logic [2:0] trk_hdr_cnt = '0;
    logic [5:0] trk_fields = '0;
    logic [7:0] trk_len = '0;
    logic [4:0] trk_ck_hi = '0;
    logic [2:0] trk_kind = KIND_NONE;

    nmea_sentence_checker u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_out      (m_char_out),
        .m_field_number  (m_field_number),
        .m_in_field      (m_in_field),
        .m_sentence_kind (m_sentence_kind),
        .m_status        (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic stim_entry_t plain_row(input logic [7:0] c);
        stim_entry_t e;
        e = '0;
        e.res.ch = c;
        return e;
    endfunction

    function automatic stim_entry_t checked_row(input logic [7:0] c, input logic [5:0] fld,
                                                input logic inf, input logic [2:0] knd,
                                                input status_t st);
        stim_entry_t e;
        e.typed = 1'b1;
        e.res.ch = c;
        e.res.field = fld;
        e.res.in_field = inf;
        e.res.kind = knd;
        e.res.status = st;
        return e;
    endfunction

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return 5'(c - "0");
        end
        if (c >= "A" && c <= "F") begin
            return 5'(c - "A" + 8'd10);
        end
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'("0" + n) : 8'("A" + n - 4'd10);
    endfunction

    function automatic logic [2:0] kind_of_header(input header_t h);
        logic [2:0] k;
        k = KIND_NONE;
        for (int i = 0; i < NUM_KINDS; i++) begin
            if (k == KIND_NONE && h == SENT_HDRS[i]) begin
                k = 3'(i);
            end
        end
        return k;
    endfunction

    // Advance the tracker by one character and return the result it should produce.
    function automatic char_result_t parse_char(input logic [7:0] c);
        char_result_t r;
        logic [4:0] lo;
        r = '0;
        r.ch = c;
        r.kind = KIND_NONE;
        r.status = ST_NONE;
        if (c == CHAR_DOLLAR) begin
            if (trk_mode != MODE_IDLE) begin
                r.status = ST_DISCARD;
            end
            trk_mode = MODE_HEAD;
            trk_xor = '0;
            trk_hdr = '0;
            trk_hdr_cnt = '0;
            trk_fields = '0;
            trk_len = 8'd1;
            trk_ck_hi = '0;
            trk_kind = KIND_NONE;
        end else if (trk_mode != MODE_IDLE) begin
            r.field = trk_fields;
            r.kind = trk_kind;
            if (trk_len >= LEN_LIMIT) begin
                r.status = ST_DISCARD;
                trk_mode = MODE_IDLE;
                trk_kind = KIND_NONE;
            end else begin
                trk_len = trk_len + 8'd1;
                case (trk_mode)
                    MODE_HEAD: begin
                        trk_xor = trk_xor ^ c;
                        trk_hdr = {trk_hdr[31:0], c};
                        trk_hdr_cnt = trk_hdr_cnt + 3'd1;
                        if (trk_hdr_cnt >= 3'(HDR_CHARS)) begin
                            trk_kind = kind_of_header(trk_hdr);
                            r.kind = trk_kind;
                            if (trk_kind == KIND_NONE) begin
                                r.status = ST_DISCARD;
                                trk_mode = MODE_IDLE;
                            end else begin
                                trk_mode = MODE_BODY;
                            end
                        end
                    end
                    MODE_BODY: begin
                        if (c == CHAR_STAR) begin
                            trk_mode = MODE_CK1;
                        end else begin
                            trk_xor = trk_xor ^ c;
                            if (c == CHAR_COMMA) begin
                                if (trk_fields != FIELD_MAX) begin
                                    trk_fields = trk_fields + 6'd1;
                                end
                            end else begin
                                r.in_field = 1'b1;
                            end
                        end
                    end
                    MODE_CK1: begin
                        trk_ck_hi = hex_nibble(c);
                        trk_mode = MODE_CK2;
                    end
                    default: begin
                        lo = hex_nibble(c);
                        r.status = (!trk_ck_hi[4] && !lo[4] &&
                                    {trk_ck_hi[3:0], lo[3:0]} == trk_xor) ? ST_OK : ST_BAD;
                        trk_mode = MODE_IDLE;
                        trk_kind = KIND_NONE;
                    end
                endcase
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] random_char(input logic allow_star);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (c == CHAR_DOLLAR || (!allow_star && c == CHAR_STAR));
        return c;
    endfunction

    // Lower-case hex half the time, otherwise anything that is not upper-case hex.
    function automatic logic [7:0] bad_digit();
        logic [7:0] c;
        logic [4:0] v;
        if ($urandom_range(1) == 0) begin
            return 8'("a" + $urandom_range(5));
        end
        do begin
            c = random_char(1'b1);
            v = hex_nibble(c);
        end while (!v[4]);
        return c;
    endfunction

    task automatic add_sentence(input shape_t shape, input int serial);
        logic [7:0] sum, c, hi, lo;
        int n_body, cut_stage;
        sum = '0;
        cut_stage = $urandom_range(3);
        stim_q.push_back(plain_row(CHAR_DOLLAR));
        for (int i = 0; i < HDR_CHARS; i++) begin
            if (shape == SENT_CUT && cut_stage == 0 && i == 2) begin
                return;
            end
            if (shape == SENT_UNKNOWN) begin
                c = random_char(1'b1);
            end else begin
                c = SENT_HDRS[serial % NUM_KINDS][8*(HDR_CHARS-1-i) +: 8];
            end
            sum = sum ^ c;
            stim_q.push_back(plain_row(c));
        end
        case (shape)
            SENT_LONG:       n_body = (serial == 0) ? 140 : $urandom_range(140, 118);
            SENT_MANYFIELDS: n_body = 70;
            default:         n_body = $urandom_range(30, 0);
        endcase
        for (int i = 0; i < n_body; i++) begin
            if (shape == SENT_MANYFIELDS || $urandom_range(3) == 0) begin
                c = CHAR_COMMA;
            end else begin
                c = random_char(1'b0);
            end
            sum = sum ^ c;
            stim_q.push_back(plain_row(c));
        end
        if (shape == SENT_CUT && cut_stage == 1) begin
            return;
        end
        stim_q.push_back(plain_row(CHAR_STAR));
        if (shape == SENT_BADSUM) begin
            sum = sum ^ 8'($urandom_range(255, 1));
        end
        hi = hex_char(sum[7:4]);
        lo = hex_char(sum[3:0]);
        if (shape == SENT_BADDIGIT) begin
            case ($urandom_range(2))
                0: hi = bad_digit();
                1: lo = bad_digit();
                default: begin
                    hi = bad_digit();
                    lo = bad_digit();
                end
            endcase
        end
        stim_q.push_back(plain_row(hi));
        if (shape == SENT_CUT && cut_stage == 2) begin
            return;
        end
        stim_q.push_back(plain_row(lo));
    endtask

    // Phase of the run: receiver slow, then sender slow, then both at full rate.
    function automatic int idle_pct(input logic sender);
        int third;
        third = stim_q.size() / 3;
        if (feed_idx < third) begin
            return sender ? 11 : 86;
        end
        if (feed_idx < 2 * third) begin
            return sender ? 86 : 11;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : feed_side
        stim_entry_t acc;
        char_result_t pred;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                acc = stim_q[chars_accepted];
                pred = parse_char(acc.res.ch);
                expected_chars.push_back(acc.typed ? acc.res : pred);
                chars_accepted <= chars_accepted + 1;
            end
            // hold the payload until the transaction completes
            if (!s_valid || s_ready) begin
                if (feed_idx < stim_q.size() && $urandom_range(99) >= idle_pct(1'b1)) begin
                    s_valid <= 1'b1;
                    s_data_byte <= stim_q[feed_idx].res.ch;
                    feed_idx <= feed_idx + 1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10) begin
                        $display("extra result: ch %02h fld %0d inf %0b kind %0d st %0d",
                                 m_char_out, m_field_number, m_in_field, m_sentence_kind,
                                 m_status);
                    end
                end else begin
                    rx_expect = expected_chars.pop_front();
                    if (m_char_out !== rx_expect.ch || m_field_number !== rx_expect.field ||
                        m_in_field !== rx_expect.in_field || m_sentence_kind !== rx_expect.kind ||
                        m_status !== rx_expect.status) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10) begin
                            $display("mismatch: exp ch %02h fld %0d inf %0b kind %0d st %0d",
                                     rx_expect.ch, rx_expect.field, rx_expect.in_field,
                                     rx_expect.kind, rx_expect.status);
                            $display("          got ch %02h fld %0d inf %0b kind %0d st %0d",
                                     m_char_out, m_field_number, m_in_field, m_sentence_kind,
                                     m_status);
                        end
                    end
                end
            end
            m_ready <= !rx_hold && ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // Stall the result side for a long stretch while the sender keeps pushing.
    initial begin
        wait (aresetn);
        while (feed_idx < 2 * (stim_q.size() / 3) + 20) begin
            @(posedge aclk);
        end
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout with %0d results pending", expected_chars.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int serial;
        int r;
        shape_t shape;
        directed_rows = '{
            checked_row(8'h00,       6'd0, 1'b0, KIND_NONE, ST_NONE),
            checked_row(CHAR_DOLLAR, 6'd0, 1'b0, KIND_NONE, ST_NONE),
            plain_row("G"), plain_row("P"), plain_row("G"), plain_row("G"),
            checked_row("A",         6'd0, 1'b0, KIND_GGA,  ST_NONE),
            checked_row(CHAR_COMMA,  6'd0, 1'b0, KIND_GGA,  ST_NONE),
            plain_row("1"), plain_row(CHAR_STAR), plain_row("4"),
            checked_row("B",         6'd1, 1'b0, KIND_GGA,  ST_OK),
            // comma and star inside the header, top byte value closes it
            checked_row(CHAR_DOLLAR, 6'd0, 1'b0, KIND_NONE, ST_NONE),
            plain_row("G"), plain_row(CHAR_COMMA), plain_row(CHAR_STAR), plain_row("Z"),
            checked_row(8'hFF,       6'd0, 1'b0, KIND_NONE, ST_DISCARD),
            // dollar in the middle of a header restarts the sentence
            checked_row(CHAR_DOLLAR, 6'd0, 1'b0, KIND_NONE, ST_NONE),
            plain_row("G"), plain_row("P"),
            checked_row(CHAR_DOLLAR, 6'd0, 1'b0, KIND_NONE, ST_DISCARD),
            plain_row("G"), plain_row("P"), plain_row("Z"), plain_row("D"),
            checked_row("A",         6'd0, 1'b0, KIND_ZDA,  ST_NONE),
            plain_row(CHAR_STAR), plain_row("a"),
            checked_row("0",         6'd0, 1'b0, KIND_ZDA,  ST_BAD)
        };
        for (int i = 0; i < N_DIRECTED; i++) begin
            stim_q.push_back(directed_rows[i]);
        end

        serial = 0;
        while (stim_q.size() < ITEM_TARGET) begin
            if ($urandom_range(9) < 3) begin
                repeat ($urandom_range(6, 1)) begin
                    stim_q.push_back(plain_row(8'($urandom_range(255))));
                end
            end
            r = $urandom_range(99);
            if (serial == 0) begin
                shape = SENT_LONG;
            end else if (serial == 1) begin
                shape = SENT_MANYFIELDS;
            end else if (serial == 2) begin
                shape = SENT_BADDIGIT;
            end else if (r < 55) begin
                shape = SENT_GOOD;
            end else if (r < 63) begin
                shape = SENT_BADSUM;
            end else if (r < 70) begin
                shape = SENT_BADDIGIT;
            end else if (r < 78) begin
                shape = SENT_UNKNOWN;
            end else if (r < 83) begin
                shape = SENT_LONG;
            end else if (r < 86) begin
                shape = SENT_MANYFIELDS;
            end else begin
                shape = SENT_CUT;
            end
            add_sentence(shape, serial);
            serial++;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (chars_accepted != stim_q.size()) begin
            @(posedge aclk);
        end
        while (expected_chars.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/nsc_pkg.sv
src/nsc_parser.sv
src/nmea_sentence_checker.sv
src/nsc_checker.sv
verif/tb_nmea_sentence_checker.sv
